// File: hw/rtl/ansi_csi_color_parser_top_defines.svh
// Assertion macros shared by the checker of the console escape parser.
`ifndef ANSI_CSI_COLOR_PARSER_TOP_DEFINES_SVH
`define ANSI_CSI_COLOR_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACP_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACP_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error(msg);

`endif

// File: hw/rtl/acp_pkg.sv
// Shared types, constants and lookup functions of the console escape parser.
package acp_pkg;

  localparam int unsigned RGB_W  = 24;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CHAR_ESC  = 8'h1B;
  localparam logic [BYTE_W-1:0] CHAR_LBR  = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CHAR_SGR  = 8'h6D;  // 'm'

  localparam logic [RGB_W-1:0] RESET_DEFAULT_FG = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] RESET_DEFAULT_BG = 24'h000000;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  // One emitted character together with the colors it is drawn in.
  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] ch;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
  } acp_glyph_t;

  function automatic logic [RGB_W-1:0] palette(input logic [2:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      3'd0:    c = 24'h000000;
      3'd1:    c = 24'hAA0000;
      3'd2:    c = 24'h00AA00;
      3'd3:    c = 24'h808000;
      3'd4:    c = 24'h0000AA;
      3'd5:    c = 24'hAA00AA;
      3'd6:    c = 24'h00AAAA;
      default: c = 24'hAAAAAA;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  // Letters that terminate a control sequence: ABCDEFGHJKSTfmsu.
  function automatic logic is_command(input logic [BYTE_W-1:0] b);
    return (b inside {[8'h41:8'h48], 8'h4A, 8'h4B, 8'h53, 8'h54,
                      8'h66, 8'h6D, 8'h73, 8'h75});
  endfunction

endpackage

// File: hw/rtl/acp_parse_core.sv
// Escape sequence state machine and color state of the console parser.
module acp_parse_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic [7:0]               step_byte,
  input  logic                     step_last,
  input  logic [23:0]              def_fg,
  input  logic [23:0]              def_bg,
  output acp_pkg::acp_glyph_t      glyph
);
  import acp_pkg::*;

  typedef enum logic [2:0] {
    MODE_TEXT        = 3'd0,
    MODE_ESC         = 3'd1,
    MODE_CSI_START   = 3'd2,
    MODE_FIRST_PARAM = 3'd3,
    MODE_AFTER_SEMI  = 3'd4,
    MODE_LATER_PARAM = 3'd5
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [7:0]       param_r, param_nxt;
  logic             seen_r, seen_nxt;
  logic [RGB_W-1:0] fg_r, fg_nxt;
  logic [RGB_W-1:0] bg_r, bg_nxt;
  logic             rev_r, rev_nxt;

  logic             emit;
  logic             cmd_end;
  logic [7:0]       p_eff;
  logic [11:0]      accum;
  logic [7:0]       p_fg_off;
  logic [7:0]       p_bg_off;

  assign accum    = {4'd0, param_r} * 12'd10 + {8'd0, step_byte[3:0]};
  assign p_eff    = seen_r ? param_r : 8'd0;
  assign p_fg_off = p_eff - 8'd30;
  assign p_bg_off = p_eff - 8'd40;

  always_comb begin
    mode_nxt  = mode_r;
    param_nxt = param_r;
    seen_nxt  = seen_r;
    emit      = 1'b0;
    cmd_end   = 1'b0;
    case (mode_r)
      MODE_ESC: begin
        if (step_byte == CHAR_LBR) begin
          mode_nxt  = MODE_CSI_START;
          param_nxt = 8'd0;
          seen_nxt  = 1'b0;
        end else if (step_byte == CHAR_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_TEXT;
          emit     = 1'b1;
        end
      end
      MODE_CSI_START: begin
        if (is_digit(step_byte)) begin
          param_nxt = {4'd0, step_byte[3:0]};
          seen_nxt  = 1'b1;
          mode_nxt  = MODE_FIRST_PARAM;
        end else begin
          cmd_end  = is_command(step_byte);
          mode_nxt = MODE_TEXT;
        end
      end
      MODE_FIRST_PARAM, MODE_LATER_PARAM: begin
        if (is_digit(step_byte)) begin
          if (mode_r == MODE_FIRST_PARAM) begin
            param_nxt = (accum > 12'd255) ? 8'd255 : accum[7:0];
          end
        end else if (step_byte == CHAR_SEMI) begin
          mode_nxt = MODE_AFTER_SEMI;
        end else begin
          cmd_end  = is_command(step_byte);
          mode_nxt = MODE_TEXT;
        end
      end
      MODE_AFTER_SEMI: begin
        mode_nxt = is_digit(step_byte) ? MODE_LATER_PARAM : MODE_TEXT;
      end
      default: begin
        if (step_byte == CHAR_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_TEXT;
          emit     = 1'b1;
        end
      end
    endcase
    if (step_last) begin
      mode_nxt = MODE_TEXT;
    end
  end

  // Select graphic rendition: only the first parameter matters.
  always_comb begin
    fg_nxt  = fg_r;
    bg_nxt  = bg_r;
    rev_nxt = rev_r;
    if (cmd_end && (step_byte == CHAR_SGR)) begin
      if (p_eff == 8'd0) begin
        fg_nxt = def_fg;
        bg_nxt = def_bg;
      end else if (p_eff == 8'd7) begin
        if (!rev_r) begin
          fg_nxt  = bg_r;
          bg_nxt  = fg_r;
          rev_nxt = 1'b1;
        end
      end else if (p_eff == 8'd27) begin
        if (rev_r) begin
          fg_nxt  = bg_r;
          bg_nxt  = fg_r;
          rev_nxt = 1'b0;
        end
      end else if (p_eff inside {[8'd30:8'd37]}) begin
        fg_nxt = palette(p_fg_off[2:0]);
      end else if (p_eff inside {[8'd40:8'd47]}) begin
        bg_nxt = palette(p_bg_off[2:0]);
      end
    end
  end

  // Emitting steps never change the colors, so the current ones go out.
  assign glyph.emit = step_en && emit;
  assign glyph.ch   = step_byte;
  assign glyph.fg   = fg_r;
  assign glyph.bg   = bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      param_r <= 8'd0;
      seen_r  <= 1'b0;
      fg_r    <= RESET_DEFAULT_FG;
      bg_r    <= RESET_DEFAULT_BG;
      rev_r   <= 1'b0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      param_r <= param_nxt;
      seen_r  <= seen_nxt;
      fg_r    <= fg_nxt;
      bg_r    <= bg_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule

// File: hw/rtl/ansi_csi_color_parser_top.sv
// Top level of the console escape sequence parser and color tracker.
//
// Console bytes arrive as beats on the in_ stream, one byte per beat, with
// in_tlast marking the last byte of a write call; any escape or control
// sequence still open after that byte is abandoned. Printable and control
// bytes leave on the out_ stream together with the foreground and
// background colors in effect. Escape sequences are removed; the SGR
// command 'm' updates the colors.
// The block takes one beat per cycle while the receiver does not stall. A
// byte is held in the input register and then evaluated by the parser
// state machine, whose next-state logic is combinational. The result
// register takes the glyph when it is free or being drained, and the glyph
// is offered on the out_ stream from that register. Bytes that belong to a
// sequence produce no output beat.
// When the receiver stalls, the result register holds its beat and the
// input register may still fill, so in_tready drops only when both are
// occupied. Reset empties both registers, puts the parser in text mode,
// clears reverse video and loads white on black as default and current
// colors. The cfg_ port writes the default colors at any edge with cfg_we.
module ansi_csi_color_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // last_in_write
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] glyph_byte, [31:8] foreground, [55:32] background
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);
  import acp_pkg::*;

  logic [RGB_W-1:0] def_fg_r;
  logic [RGB_W-1:0] def_bg_r;

  // Input register stage.
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  // Result register stage.
  logic             out_valid_r;
  logic [55:0]      out_data_r;

  logic             s2_ready;
  logic             s1_advance;
  logic             in_accept;
  acp_glyph_t       glyph;

  assign s2_ready   = !out_valid_r || out_tready;
  assign s1_advance = s1_valid_r && s2_ready;
  assign in_tready  = !s1_valid_r || s2_ready;
  assign in_accept  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_fg_r <= RESET_DEFAULT_FG;
      def_bg_r <= RESET_DEFAULT_BG;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEFAULT_FG) begin
        def_fg_r <= cfg_wdata;
      end else begin
        def_bg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  acp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_advance),
    .step_byte (s1_byte_r),
    .step_last (s1_last_r),
    .def_fg    (def_fg_r),
    .def_bg    (def_bg_r),
    .glyph     (glyph)
  );

  // The result register reloads whenever it is free or being drained;
  // a swallowed byte simply leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= glyph.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && glyph.emit) begin
      out_data_r <= {glyph.bg, glyph.fg, glyph.ch};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/acp_checker.sv
// Port-level assertion checker for the console parser and its bind.
`include "ansi_csi_color_parser_top_defines.svh"

module acp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  `ACP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output beat changed")
  `ACP_ASSERT_IMPLY(a_out_after_in, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready, 2), "output beat without an input beat two cycles before")
  `ACP_ASSERT_IMPLY(a_no_esc_out, clk, rst_n, out_tvalid, out_tdata[7:0] != 8'h1B, "escape byte leaked to the output")
  `ACP_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled while the output is empty")

endmodule

bind ansi_csi_color_parser_top acp_checker u_acp_checker (.*);

// File: tb/tb_ansi_csi_color_parser_top.sv
// Testbench for the console escape parser: self-predicting stream test with random flow control.
module tb_ansi_csi_color_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acp_pkg::*;

  // Run limit in clock cycles, set far above the slowest correct run: about 500
  // beats, each with short random gaps on both sides and a pipe of input and
  // result registers.
  localparam int unsigned RUN_LIMIT = 200000;

  // Cycles allowed for the pipe to drain once nothing more is expected. The block
  // holds a byte in its input and result registers, and swallowed bytes leave no trace at the output.
  localparam int unsigned DRAIN_CYCLES = 12;

  // Characters that the parser treats specially.
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'

  // SGR parameter values that have an effect.
  localparam int SGR_RESET      = 0;
  localparam int SGR_REVERSE    = 7;
  localparam int SGR_NO_REVERSE = 27;
  localparam int SGR_FG_FIRST   = 30;
  localparam int SGR_FG_LAST    = 37;
  localparam int SGR_BG_FIRST   = 40;
  localparam int SGR_BG_LAST    = 47;
  localparam int PARAM_CEILING  = 255;

  // Every letter that closes a control sequence.
  localparam string COMMAND_LETTERS = "ABCDEFGHJKSTfmsu";

  // Where the parser stands between two bytes.
  typedef enum logic [2:0] {
    PM_TEXT,
    PM_ESC,
    PM_CSI_START,
    PM_FIRST_PARAM,
    PM_AFTER_SEMI,
    PM_LATER_PARAM
  } parse_mode_t;

  // One glyph as it should leave the block.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic [RGB_W-1:0]  fg;
    logic [RGB_W-1:0]  bg;
  } glyph_t;

  // Tracks the console state and keeps, oldest first, the glyphs still to come.
  class console_model;
    logic [RGB_W-1:0] base_fg;
    logic [RGB_W-1:0] base_bg;
    parse_mode_t      mode;
    logic [7:0]       param;
    logic             param_seen;
    logic [RGB_W-1:0] cur_fg;
    logic [RGB_W-1:0] cur_bg;
    logic             reversed;
    glyph_t           pending_glyphs[$];
    int unsigned      mismatches;

    function new();
      base_fg    = RESET_DEFAULT_FG;
      base_bg    = RESET_DEFAULT_BG;
      mode       = PM_TEXT;
      param      = '0;
      param_seen = 1'b0;
      cur_fg     = RESET_DEFAULT_FG;
      cur_bg     = RESET_DEFAULT_BG;
      reversed   = 1'b0;
      mismatches = 0;
    endfunction

    function int pending_count();
      return pending_glyphs.size();
    endfunction

    function void set_default(logic idx, logic [RGB_W-1:0] value);
      if (idx == CFG_DEFAULT_FG) base_fg = value;
      else base_bg = value;
    endfunction

    static function bit digit(logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    static function bit closes_sequence(logic [7:0] b);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < COMMAND_LETTERS.len(); i++) begin
        if (COMMAND_LETTERS[i] == b) hit = 1'b1;
      end
      return hit;
    endfunction

    static function logic [RGB_W-1:0] eight_color(int idx);
      case (idx)
        0:       return 24'h000000;
        1:       return 24'hAA0000;
        2:       return 24'h00AA00;
        3:       return 24'h808000;
        4:       return 24'h0000AA;
        5:       return 24'hAA00AA;
        6:       return 24'h00AAAA;
        default: return 24'hAAAAAA;
      endcase
    endfunction

    function void swap_colors();
      logic [RGB_W-1:0] t;
      t      = cur_fg;
      cur_fg = cur_bg;
      cur_bg = t;
    endfunction

    // Apply the command that closed a sequence. Only SGR touches the colors.
    function void apply_command(logic [7:0] cmd);
      int p;
      p = param_seen ? int'(param) : SGR_RESET;
      if (cmd != CHAR_SGR) return;
      if (p == SGR_RESET) begin
        cur_fg = base_fg;
        cur_bg = base_bg;
      end else if (p == SGR_REVERSE) begin
        if (!reversed) begin
          swap_colors();
          reversed = 1'b1;
        end
      end else if (p == SGR_NO_REVERSE) begin
        if (reversed) begin
          swap_colors();
          reversed = 1'b0;
        end
      end else if (p >= SGR_FG_FIRST && p <= SGR_FG_LAST) begin
        cur_fg = eight_color(p - SGR_FG_FIRST);
      end else if (p >= SGR_BG_FIRST && p <= SGR_BG_LAST) begin
        cur_bg = eight_color(p - SGR_BG_FIRST);
      end
    endfunction

    // Advance the parser by one accepted input beat.
    function void note_byte(logic [7:0] b, logic last);
      bit     emit;
      int     v;
      glyph_t g;
      emit = 1'b0;
      case (mode)
        PM_ESC: begin
          if (b == CHAR_LBR) begin
            mode       = PM_CSI_START;
            param      = '0;
            param_seen = 1'b0;
          end else if (b == CHAR_ESC) begin
            mode = PM_ESC;
          end else begin
            mode = PM_TEXT;
            emit = 1'b1;
          end
        end
        PM_CSI_START: begin
          if (digit(b)) begin
            param      = b - CH_ZERO;
            param_seen = 1'b1;
            mode       = PM_FIRST_PARAM;
          end else begin
            if (closes_sequence(b)) apply_command(b);
            mode = PM_TEXT;
          end
        end
        PM_FIRST_PARAM, PM_LATER_PARAM: begin
          if (digit(b)) begin
            if (mode == PM_FIRST_PARAM) begin
              v     = int'(param) * 10 + int'(b - CH_ZERO);
              param = (v > PARAM_CEILING) ? 8'(PARAM_CEILING) : 8'(v);
            end
          end else if (b == CHAR_SEMI) begin
            mode = PM_AFTER_SEMI;
          end else begin
            if (closes_sequence(b)) apply_command(b);
            mode = PM_TEXT;
          end
        end
        PM_AFTER_SEMI: begin
          mode = digit(b) ? PM_LATER_PARAM : PM_TEXT;
        end
        default: begin
          if (b == CHAR_ESC) begin
            mode = PM_ESC;
          end else begin
            mode = PM_TEXT;
            emit = 1'b1;
          end
        end
      endcase
      if (last) mode = PM_TEXT;
      if (emit) begin
        g.ch = b;
        g.fg = cur_fg;
        g.bg = cur_bg;
        pending_glyphs.push_back(g);
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one output beat with the oldest glyph still expected.
    task check_glyph(logic [55:0] beat);
      glyph_t g;
      if (pending_glyphs.size() == 0) begin
        report($sformatf("output beat %h with no glyph expected", beat));
        return;
      end
      g = pending_glyphs.pop_front();
      if (beat[7:0] !== g.ch)
        report($sformatf("glyph %h, expected %h", beat[7:0], g.ch));
      if (beat[31:8] !== g.fg)
        report($sformatf("foreground %h, expected %h (glyph %h)", beat[31:8], g.fg, g.ch));
      if (beat[55:32] !== g.bg)
        report($sformatf("background %h, expected %h (glyph %h)", beat[55:32], g.bg, g.ch));
    endtask
  endclass

  // Every block input starts at a known value.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] byte_in
  logic        in_tlast   = 1'b0; // last_in_write
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // [7:0] glyph_byte, [31:8] foreground, [55:32] background
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [23:0] cfg_wdata  = '0;

  console_model model = new();

  // When set, neither side inserts idle cycles: a long stretch at full rate.
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;
  // Input beats taken by the block so far.
  int unsigned beats_sent = 0;

  ansi_csi_color_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a lost beat ends the run here.
  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // The receiver stalls in about one cycle of ten. The decision is made at the
  // falling edge, so it is stable by the rising edge where the beat moves.
  always @(negedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // Every output beat that is taken is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_glyph(out_tdata);
  end

  // Offer one byte and hold it until the block takes it. Idle gaps are drawn
  // cycle by cycle ahead of the beat, so they land on any phase of the pipe.
  // in_tvalid gets a single assignment per falling edge, never a drop and rise.
  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    model.note_byte(b, last);
    beats_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  // A string of bytes; the end of write flag can mark the final one.
  task automatic send_text(string s, bit last_at_end = 1'b0);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Occasional write boundaries, so that open sequences are also cut short.
  function automatic logic random_last();
    return $urandom_range(99) < 3;
  endfunction

  task automatic send_digits(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], random_last());
  endtask

  // The default colors change only with the block at rest: no glyph pending and
  // a pause long enough for a swallowed byte to clear the pipe as well.
  task automatic write_default(logic idx, logic [RGB_W-1:0] value);
    stop_input();
    while (model.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    model.set_default(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Short directed walk over the color commands and the corner cases.
  task automatic directed_part();
    send_byte(8'h00, 1'b0);               // lowest byte as plain text
    send_byte(8'hFF, 1'b1);               // highest byte, ends a write
    send_text("\033[31mr\033[44mb");      // foreground and background from the table
    send_text("\033[7mv\033[7mv");        // reverse video, then again with no effect
    send_text("\033[0md");                // defaults back, reverse flag stays set
    send_text("\033[27mn\033[27mn");      // reverse off, then again with no effect
    send_text("\033[35m\033[mz");         // SGR with no parameter acts as a reset
    send_text("\033[999m\033[32;45mp");   // saturated parameter has no meaning
    send_text("\033[2J\033[H\033[sq");    // other commands are consumed silently
    send_text("\033[3Xe\033[;f\033[1;;g"); // broken sequences swallow the bad byte
    send_text("\033Q\033\033[36mh");      // lone escapes are dropped
    send_text("\033[3", 1'b1);            // sequence cut by the end of a write
    send_text("1m");                      // so these come out as text
    send_byte(CHAR_ESC, 1'b1);            // pending escape cut the same way
    send_text("[k");
    send_text("\033[33", 1'b0);
    send_byte(8'h80, 1'b0);               // high byte breaks a parameter
    send_text("\033[1;2", 1'b0);
    send_byte(8'h00, 1'b0);               // NUL breaks a later parameter
    send_text("\033[37m", 1'b1);          // closing byte with end of write still acts
    send_text("w");
  endtask

  // SGR values weighted toward the ones that do something.
  function automatic int pick_param();
    int r;
    r = $urandom_range(99);
    if (r < 15) return SGR_RESET;
    if (r < 27) return SGR_REVERSE;
    if (r < 37) return SGR_NO_REVERSE;
    if (r < 57) return $urandom_range(SGR_FG_LAST, SGR_FG_FIRST);
    if (r < 77) return $urandom_range(SGR_BG_LAST, SGR_BG_FIRST);
    return $urandom_range(999);
  endfunction

  // Mostly well-formed sequences and text runs with random content; the rest
  // are escapes followed by junk.
  task automatic random_part(int unsigned beats);
    int unsigned start;
    int          r;
    int          n;
    logic [7:0]  cmd;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      r = $urandom_range(99);
      if (r < 40) begin
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom_range(255)), random_last());
      end else if (r < 85) begin
        send_byte(CHAR_ESC, random_last());
        send_byte(CHAR_LBR, random_last());
        if ($urandom_range(9) != 0) begin
          send_digits(pick_param());
          repeat ($urandom_range(2)) begin
            send_byte(CHAR_SEMI, random_last());
            send_digits($urandom_range(99));
          end
        end
        cmd = ($urandom_range(99) < 70) ? CHAR_SGR
                                        : COMMAND_LETTERS[$urandom_range(15)];
        send_byte(cmd, random_last());
      end else begin
        send_byte(CHAR_ESC, random_last());
        if ($urandom_range(1)) send_byte(CHAR_LBR, random_last());
        if ($urandom_range(1)) send_digits($urandom_range(50));
        if ($urandom_range(2) == 0) send_byte(CHAR_SEMI, random_last());
        n = $urandom_range(3, 1);
        repeat (n) send_byte(8'($urandom_range(255)), random_last());
      end
    end
  endtask

  initial begin
    // Reset is held from the start and released at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one runs with the reset defaults, white on black.
    directed_part();
    random_part(90);

    // Extreme defaults the other way round, with a long stretch at full rate.
    write_default(CFG_DEFAULT_FG, 24'h000000);
    write_default(CFG_DEFAULT_BG, 24'hFFFFFF);
    no_idle = 1'b1;
    random_part(100);
    no_idle = 1'b0;

    // Arbitrary defaults.
    write_default(CFG_DEFAULT_FG, 24'($urandom()));
    write_default(CFG_DEFAULT_BG, 24'($urandom()));
    random_part(90);

    write_default(CFG_DEFAULT_FG, 24'hFFFFFF);
    write_default(CFG_DEFAULT_BG, 24'($urandom()));
    random_part(90);

    // Let every predicted glyph arrive, then give the pipe time to show strays.
    stop_input();
    while (model.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (model.pending_count() != 0) model.report("glyphs still expected at the end");
    if (model.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
